>>> hdl/mntg_pkg.sv
// ============================================================================
// Tone generator package
// Shared types, register codes and elaboration-time table functions for the
// single-voice sine tone generator.
// ============================================================================
`timescale 1ns / 1ps

package mntg_pkg;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_SAMPLES  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_STEP     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_SAMPLES = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_STEP    = CFG_INDEX_W'(3);

    localparam logic [15:0] RST_ATTACK_SAMPLES  = 16'd220;
    localparam logic [15:0] RST_ATTACK_STEP     = 16'd298;
    localparam logic [15:0] RST_RELEASE_SAMPLES = 16'd4410;
    localparam logic [15:0] RST_RELEASE_STEP    = 16'd15;

    // Widest sine table index that a request can carry.
    localparam int unsigned SIDX_W_MAX = 14;

    // Number of MIDI notes in the phase step table.
    localparam int unsigned NOTE_COUNT = 128;

    // Depth of the request queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Envelope full scale in Q1.16.
    localparam logic [16:0] ENV_ONE = 17'h10000;

    // Output saturation limits.
    localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;

    // Fixed-point constants used by the table functions.
    localparam longint          ONE_Q30      = 64'sd1073741824;
    localparam longint unsigned ONE_Q30_U    = 64'd1073741824;
    localparam longint unsigned SEMITONE_Q30 = 64'd1137589835;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] attack_samples;
        logic [15:0] attack_step;
        logic [15:0] release_samples;
        logic [15:0] release_step;
    } cfg_t;

    // One classified tick request handed from front to back.
    typedef struct packed {
        logic                  active;
        logic                  last;
        logic [SIDX_W_MAX-1:0] sidx;
        logic                  env_full;
        logic [15:0]           env_arg;
        logic [15:0]           env_step;
        logic [15:0]           volume;
    } tick_req_t;

    // Q30 product truncated toward zero.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / ONE_Q30;
    endfunction

    // Frequency ratio 2^(semi/12) in Q30, rounded half up at each step.
    function automatic longint unsigned semitone_ratio(input int unsigned semi);
        longint unsigned r;
        int unsigned     k;
        r = ONE_Q30_U;
        for (k = 0; k < semi; k++)
        begin
            r = (r * SEMITONE_Q30 + (64'd1 << 29)) >> 30;
        end
        return r;
    endfunction

    // One Q1.15 entry of a full-wave sine table with 2^bits entries.
    function automatic logic [15:0] sine_value(input int unsigned idx,
                                               input int unsigned bits);
        int unsigned qb;
        int unsigned qlen;
        int unsigned quad;
        int unsigned k;
        longint      u;
        longint      t;
        longint      p;
        longint      v;
        qb   = bits - 2;
        qlen = 1 << qb;
        quad = (idx >> qb) & 3;
        k    = idx & (qlen - 1);
        if ((quad & 1) != 0)
        begin
            k = qlen - k;
        end
        u = longint'(k) << (30 - qb);
        t = qmul(u, u);
        p = 64'sd172272;
        p = qmul(p, t) - 64'sd5026995;
        p = qmul(p, t) + 64'sd85569306;
        p = qmul(p, t) - 64'sd693598668;
        p = qmul(p, t) + 64'sd1686629713;
        v = qmul(p, u);
        if (v < 0)
        begin
            v = 0;
        end
        v = (v + 16384) >>> 15;
        if (v > 32767)
        begin
            v = 32767;
        end
        return ((quad & 2) != 0) ? 16'(-v) : 16'(v);
    endfunction

endpackage

>>> hdl/midi_note_tone_generator.sv
// ============================================================================
// Single-voice MIDI tone generator
// Sine oscillator with a linear attack and release envelope.
//
// Input channel (in_valid / in_stall): func selects a start request, which
// latches note, length_samples and volume and restarts the voice, or a tick
// request, which asks for one audio sample. Start requests give no result.
// Output channel (out_valid / out_stall): one result per tick with a
// saturated Q1.15 sample, an active flag and a last flag on the final sample
// of the note. Ticks while the voice is idle return a silent, inactive sample.
// A tick's result passes through a four-entry request queue, the sample
// pipeline stages and the output register; ticks are taken one per cycle
// while the queue is not full. Start requests are held off while it is full.
// When the receiver stalls, the output register holds, the pipeline freezes
// and the queue fills; in_stall rises only when the queue is full.
// Reset clears the voice to idle, empties the queue and pipeline and loads
// the envelope registers with their defaults. The cfg_we write port updates
// the envelope registers; it is meant for use while no request is in flight.
// ============================================================================
`timescale 1ns / 1ps

module midi_note_tone_generator #(
    parameter int unsigned SAMPLE_RATE     = 44100,
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned LENGTH_BITS     = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [6:0]                           note,
    input  logic [LENGTH_BITS-1:0]               length_samples,
    input  logic [15:0]                          volume,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          sample,
    output logic                                 active,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [mntg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);
    import mntg_pkg::*;

    cfg_t      cfg_reg;
    tick_req_t push_req;
    tick_req_t head_req;
    logic      req_push;
    logic      queue_full;
    logic      queue_empty;
    logic      req_pop;

    // Envelope configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_samples  <= RST_ATTACK_SAMPLES;
            cfg_reg.attack_step     <= RST_ATTACK_STEP;
            cfg_reg.release_samples <= RST_RELEASE_SAMPLES;
            cfg_reg.release_step    <= RST_RELEASE_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ATTACK_SAMPLES:  cfg_reg.attack_samples  <= cfg_data;
                CFG_ATTACK_STEP:     cfg_reg.attack_step     <= cfg_data;
                CFG_RELEASE_SAMPLES: cfg_reg.release_samples <= cfg_data;
                CFG_RELEASE_STEP:    cfg_reg.release_step    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Front end: voice state and request classification.
    mntg_front #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .note           (note),
        .length_samples (length_samples),
        .volume         (volume),
        .cfg            (cfg_reg),
        .req_ready      (!queue_full),
        .req_push       (req_push),
        .req            (push_req)
    );

    // Request queue.
    mntg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_push),
        .push_data (push_req),
        .full      (queue_full),
        .pop       (req_pop),
        .empty     (queue_empty),
        .head      (head_req)
    );

    // Sample pipeline and output register.
    mntg_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (!queue_empty),
        .req       (head_req),
        .req_pop   (req_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .active    (active),
        .last      (last)
    );

endmodule

>>> hdl/mntg_front.sv
// ============================================================================
// Tone generator front end
// Accepts start and tick items, keeps the voice state and turns each tick
// into a classified request for the sample pipeline.
// ============================================================================
`timescale 1ns / 1ps

module mntg_front #(
    parameter int unsigned SAMPLE_RATE     = 44100,
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned LENGTH_BITS     = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [6:0]             note,
    input  logic [LENGTH_BITS-1:0] length_samples,
    input  logic [15:0]            volume,
    input  mntg_pkg::cfg_t         cfg,
    input  logic                   req_ready,
    output logic                   req_push,
    output mntg_pkg::tick_req_t    req
);
    import mntg_pkg::*;

    localparam int unsigned CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic [PHASE_BITS-1:0]  step_rom [NOTE_COUNT];

    logic [PHASE_BITS-1:0]  step_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [LENGTH_BITS-1:0] index_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [15:0]            volume_reg;
    logic                   sounding_reg;

    logic                   accept;
    logic                   fin;
    logic [LENGTH_BITS-1:0] rem;
    logic [CMP_W-1:0]       idx_c;
    logic [CMP_W-1:0]       rem_c;
    logic                   in_attack;
    logic                   in_release;

    // Phase step table, one entry per MIDI note, built at elaboration.
    for (genvar n = 0; n < NOTE_COUNT; n++)
    begin : g_step
        localparam int unsigned     D     = n + 51;
        localparam int unsigned     OCT   = D / 12;
        localparam int unsigned     SEMI  = D % 12;
        localparam longint unsigned NUMER = 64'd440 * semitone_ratio(SEMI);
        localparam longint unsigned QUOT  = (NUMER << 20) / SAMPLE_RATE;
        localparam int unsigned     SH    = 60 - PHASE_BITS - OCT;
        localparam longint unsigned STEP  = (QUOT + (64'd1 << (SH - 1))) >> SH;
        assign step_rom[n] = STEP[PHASE_BITS-1:0];
    end

    // Items are held off only while the request queue is full.
    assign in_stall = !req_ready;
    assign accept   = in_valid && req_ready;
    assign req_push = accept && (func == FUNC_TICK);

    // Envelope classification for the current sample index.
    assign fin        = ({1'b0, index_reg} + 1'b1) >= {1'b0, length_reg};
    assign rem        = length_reg - index_reg;
    assign idx_c      = CMP_W'(index_reg);
    assign rem_c      = CMP_W'(rem);
    assign in_attack  = idx_c < CMP_W'(cfg.attack_samples);
    assign in_release = rem_c < CMP_W'(cfg.release_samples);

    // Build the request; an idle voice gives a silent request.
    always_comb
    begin
        req          = '0;
        req.active   = sounding_reg;
        req.last     = sounding_reg && fin;
        req.sidx     = SIDX_W_MAX'(phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]);
        req.env_full = !in_attack && !in_release;
        req.env_arg  = in_attack ? idx_c[15:0] : rem_c[15:0];
        req.env_step = in_attack ? cfg.attack_step : cfg.release_step;
        req.volume   = volume_reg;
    end

    // Voice state: a start restarts the voice, a tick advances it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            phase_reg    <= '0;
            index_reg    <= '0;
            length_reg   <= '0;
            volume_reg   <= '0;
            sounding_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (func == FUNC_START)
            begin
                step_reg     <= step_rom[note];
                phase_reg    <= '0;
                index_reg    <= '0;
                length_reg   <= length_samples;
                volume_reg   <= volume;
                sounding_reg <= (length_samples != '0);
            end
            else if (sounding_reg)
            begin
                phase_reg <= phase_reg + step_reg;
                index_reg <= index_reg + 1'b1;
                if (fin)
                begin
                    sounding_reg <= 1'b0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sounding_reg |-> (index_reg < length_reg))
        else $error("sample index reached the note length while sounding");

    a_idle_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req_push && !req.active) |-> !req.last)
        else $error("idle tick request flagged as last sample");

    a_zero_length_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_START) && (length_samples == '0)) |=> !sounding_reg)
        else $error("zero length start left the voice sounding");
`endif

endmodule

>>> hdl/mntg_queue.sv
// ============================================================================
// Tone generator request queue
// Short register queue of tick requests between the front end and the
// sample pipeline.
// ============================================================================
`timescale 1ns / 1ps

module mntg_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mntg_pkg::tick_req_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mntg_pkg::tick_req_t head
);
    import mntg_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tick_req_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer wrap at the queue depth.
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request popped from an empty queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone push");
`endif

endmodule

>>> hdl/mntg_back.sv
// ============================================================================
// Tone generator sample pipeline
// Sine lookup, envelope, gain multiply, rounding and saturation, ending in
// the output register.
// ============================================================================
`timescale 1ns / 1ps

module mntg_back #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  mntg_pkg::tick_req_t req,
    output logic                req_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         sample,
    output logic                active,
    output logic                last
);
    import mntg_pkg::*;

    localparam int unsigned SINE_DEPTH = 1 << SINE_TABLE_BITS;
    localparam logic [47:0] ROUND_HALF = 48'd1 << 30;

    logic [15:0] sine_rom [SINE_DEPTH];

    logic        adv;

    // Stage 1: sine read and envelope product.
    logic        s1_valid_reg;
    logic        s1_active_reg;
    logic        s1_last_reg;
    logic        s1_full_reg;
    logic [15:0] s1_sine_reg;
    logic [31:0] s1_envp_reg;
    logic [15:0] s1_vol_reg;

    // Stage 2: saturated envelope and gain product.
    logic        s2_valid_reg;
    logic        s2_active_reg;
    logic        s2_last_reg;
    logic        s2_neg_reg;
    logic [16:0] s2_env_reg;
    logic [31:0] s2_prod_reg;

    // Stage 3: full magnitude.
    logic        s3_valid_reg;
    logic        s3_active_reg;
    logic        s3_last_reg;
    logic        s3_neg_reg;
    logic [47:0] s3_mag_reg;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] sample_reg;
    logic        active_reg;
    logic        last_reg;

    logic        sine_neg;
    logic [15:0] sine_abs;
    logic [16:0] env_sat;
    logic [47:0] mag_sum;
    logic [16:0] rnd;
    logic [15:0] sample_next;

    // Sine table, built at elaboration.
    for (genvar g = 0; g < SINE_DEPTH; g++)
    begin : g_sine
        localparam logic [15:0] SV = sine_value(g, SINE_TABLE_BITS);
        assign sine_rom[g] = SV;
    end

    // The whole pipeline moves when the output register is free or drained.
    assign adv     = !out_valid_reg || !out_stall;
    assign req_pop = adv && req_valid;

    // Stage 1 datapath.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_active_reg <= req.active;
            s1_last_reg   <= req.last;
            s1_full_reg   <= req.env_full;
            s1_sine_reg   <= sine_rom[req.sidx[SINE_TABLE_BITS-1:0]];
            s1_envp_reg   <= 32'(req.env_arg) * 32'(req.env_step);
            s1_vol_reg    <= req.volume;
        end
    end

    // Stage 2 datapath.
    assign sine_neg = s1_sine_reg[15];
    assign sine_abs = sine_neg ? (16'd0 - s1_sine_reg) : s1_sine_reg;
    assign env_sat  = (s1_full_reg || (s1_envp_reg > 32'(ENV_ONE))) ?
                      ENV_ONE : s1_envp_reg[16:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_active_reg <= s1_active_reg;
            s2_last_reg   <= s1_last_reg;
            s2_neg_reg    <= sine_neg;
            s2_env_reg    <= env_sat;
            s2_prod_reg   <= 32'(sine_abs) * 32'(s1_vol_reg);
        end
    end

    // Stage 3 datapath.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_active_reg <= s2_active_reg;
            s3_last_reg   <= s2_last_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_mag_reg    <= 48'(s2_prod_reg) * 48'(s2_env_reg);
        end
    end

    // Round half away from zero, restore the sign and saturate.
    assign mag_sum = s3_mag_reg + ROUND_HALF;
    assign rnd     = mag_sum[47:31];

    always_comb
    begin
        if (!s3_active_reg)
        begin
            sample_next = '0;
        end
        else if (s3_neg_reg)
        begin
            sample_next = (rnd > 17'd32768) ? SAMPLE_MIN : 16'(17'd0 - rnd);
        end
        else
        begin
            sample_next = (rnd > 17'd32767) ? SAMPLE_MAX : rnd[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sample_reg <= sample_next;
            active_reg <= s3_active_reg;
            last_reg   <= s3_active_reg && s3_last_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign active    = active_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !active_reg) |-> ((sample_reg == '0) && !last_reg))
        else $error("idle result carries a nonzero sample or last flag");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> req_valid)
        else $error("pipeline took a request from an empty queue");

    a_last_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_active_reg)
        else $error("last flag on a silent request");
`endif

endmodule
